// File: rtl/dd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_pkg
// Shared types, constants and calendar tables for the date difference block.
// ----------------------------------------------------------------------------
package dd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int DOY_W   = 9;

   localparam logic [YEAR_W-1:0]  YEAR_MAX      = YEAR_W'(9999);
   localparam logic [COUNT_W-1:0] DAYS_PER_YEAR = COUNT_W'(365);
   localparam logic [DAY_W-1:0]   FEB_LEAP_LEN  = DAY_W'(29);

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   typedef struct packed {
      logic [DAY_W-1:0]   day_a;
      logic [MONTH_W-1:0] month_a;
      logic [YEAR_W-1:0]  year_a;
      logic [DAY_W-1:0]   day_b;
      logic [MONTH_W-1:0] month_b;
      logic [YEAR_W-1:0]  year_b;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               first_earlier;
      logic               bad_date;
   } rsp_payload_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // Day number of one date plus its validity.
   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] num;
   } date_info_type;

   // Days before the first of the month in a common year.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] d;
      unique case (m)
         4'd2:    d = DOY_W'(31);
         4'd3:    d = DOY_W'(59);
         4'd4:    d = DOY_W'(90);
         4'd5:    d = DOY_W'(120);
         4'd6:    d = DOY_W'(151);
         4'd7:    d = DOY_W'(181);
         4'd8:    d = DOY_W'(212);
         4'd9:    d = DOY_W'(243);
         4'd10:   d = DOY_W'(273);
         4'd11:   d = DOY_W'(304);
         4'd12:   d = DOY_W'(334);
         default: d = '0;
      endcase
      return d;
   endfunction

   // Month length in a common year; zero for a month code that means nothing.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    d = DAY_W'(30);
         4'd2:                                       d = DAY_W'(28);
         default:                                    d = '0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/dd_day_num.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_day_num
// Closed-form day number and range check for one calendar date.
// ----------------------------------------------------------------------------
module dd_day_num (
   input  dd_pkg::date_type      date,
   output dd_pkg::date_info_type info
);

   logic                          leap;
   logic [dd_pkg::DAY_W-1:0]      len;
   logic [dd_pkg::YEAR_W:0]       year_plus3;
   logic [dd_pkg::COUNT_W-1:0]    year_days;
   logic [dd_pkg::COUNT_W-1:0]    leap_days;
   logic [dd_pkg::COUNT_W-1:0]    month_days;

   assign leap = (date.year[1:0] == 2'b00);

   always_comb begin
      len = dd_pkg::month_len(date.month);
      if (date.month == dd_pkg::MONTH_FEB && leap) begin
         len = dd_pkg::FEB_LEAP_LEN;
      end
   end

   assign info.ok = (date.month >= dd_pkg::MONTH_JAN) && (date.month <= dd_pkg::MONTH_DEC) &&
                    (date.year <= dd_pkg::YEAR_MAX) &&
                    (date.day != '0) && (date.day <= len);

   // Leap days of earlier years: ceil(year / 4), year zero counted as leap.
   assign year_plus3 = {1'b0, date.year} + (dd_pkg::YEAR_W+1)'(3);
   assign year_days  = dd_pkg::COUNT_W'(date.year) * dd_pkg::DAYS_PER_YEAR;
   assign leap_days  = dd_pkg::COUNT_W'(year_plus3 >> 2);
   assign month_days = dd_pkg::COUNT_W'(dd_pkg::days_before(date.month)) +
                       dd_pkg::COUNT_W'(leap && (date.month > dd_pkg::MONTH_FEB));

   assign info.num = year_days + leap_days + month_days + dd_pkg::COUNT_W'(date.day);

endmodule

// File: rtl/dd_diff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_diff
// Compare two day numbers and form the absolute distance and order flag.
// ----------------------------------------------------------------------------
module dd_diff (
   input  dd_pkg::date_info_type   info_a,
   input  dd_pkg::date_info_type   info_b,
   output dd_pkg::rsp_payload_type result
);

   logic a_less;
   logic bad;

   assign a_less = info_a.num < info_b.num;
   assign bad    = !(info_a.ok && info_b.ok);

   always_comb begin
      result.bad_date      = bad;
      result.first_earlier = a_less && !bad;
      if (bad) begin
         result.day_count = '0;
      end else if (a_less) begin
         result.day_count = info_b.num - info_a.num;
      end else begin
         result.day_count = info_a.num - info_b.num;
      end
   end

endmodule

// File: rtl/date_day_difference_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_day_difference_top
// Days between two calendar dates (leap year every fourth year), with order
// and validity flags, one date pair per clock.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                     direction
//  -------   ----------------   -------------------------   ---------
//  request   start / busy       req_data (two dates)        in
//  response  rsp_valid strobe   rsp_data (count, flags)     out
//
//  A beat is taken at each edge where start is high and busy is low; busy
//  never rises, so a new date pair may enter on every cycle.
//  Each beat passes the input register, the day number register and the result
//  register. The day number stage (constant multiply by 365 plus table add)
//  sets the cycle time.
//  Synchronous active-high reset clears the valid pipeline only.
//  The receiver cannot stall: each result shows for exactly one cycle.
//
module date_day_difference_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  dd_pkg::req_payload_type req_data,
   output logic                    rsp_valid,
   output dd_pkg::rsp_payload_type rsp_data
);

   // Input register stage.
   logic                    in_valid_ff;
   logic                    in_valid_in;
   dd_pkg::req_payload_type in_data_ff;

   // Day number stage.
   logic                    num_valid_ff;
   dd_pkg::date_info_type   info_a_ff;
   dd_pkg::date_info_type   info_b_ff;
   dd_pkg::date_info_type   info_a_in;
   dd_pkg::date_info_type   info_b_in;

   // Result register stage.
   logic                    out_valid_ff;
   dd_pkg::rsp_payload_type out_data_ff;
   dd_pkg::rsp_payload_type out_data_in;

   dd_pkg::date_type        date_a;
   dd_pkg::date_type        date_b;

   // Nothing ever backs up: results leave as they are made.
   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_valid_in) begin
         in_data_ff <= req_data;
      end
   end

   assign date_a = '{day: in_data_ff.day_a, month: in_data_ff.month_a, year: in_data_ff.year_a};
   assign date_b = '{day: in_data_ff.day_b, month: in_data_ff.month_b, year: in_data_ff.year_b};

   // One day number unit per date.
   dd_day_num u_num_a (
      .date (date_a),
      .info (info_a_in)
   );

   dd_day_num u_num_b (
      .date (date_b),
      .info (info_b_in)
   );

   // Hold the day numbers for the compare stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else begin
         num_valid_ff <= in_valid_ff;
      end
      if (in_valid_ff) begin
         info_a_ff <= info_a_in;
         info_b_ff <= info_b_in;
      end
   end

   dd_diff u_diff (
      .info_a (info_a_ff),
      .info_b (info_b_ff),
      .result (out_data_in)
   );

   // Advance into the result register; the strobe lasts one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= num_valid_ff;
      end
      if (num_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A result strobe always traces back to a request beat taken earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result strobe without matching request beat");

   // A bad date reports neither distance nor order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_date) |-> (rsp_data.day_count == '0 && !rsp_data.first_earlier))
      else $error("bad date carries a nonzero result");

   // Strict precedence implies a nonzero distance.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.first_earlier) |-> (rsp_data.day_count != '0))
      else $error("first date earlier but zero distance");

   // Day numbers of valid dates stay inside the count range.
   assert property (@(posedge clock) disable iff (reset)
      (num_valid_ff && info_a_ff.ok) |->
         (info_a_ff.num <= dd_pkg::COUNT_W'(dd_pkg::YEAR_MAX) * dd_pkg::DAYS_PER_YEAR +
                           dd_pkg::COUNT_W'(3000)))
      else $error("day number out of range");

endmodule

// File: dv/tb_date_day_difference_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_day_difference_top
// Self-checking bench for the date difference block: a directed vector table
// (calendar extremes, leap days, every kind of bad date) followed by random
// date pairs, mostly valid with random content, each one scored against a
// behavioral day count model. Sender gaps come in random bursts.
// ----------------------------------------------------------------------------
module tb_date_day_difference_top;

   import dd_pkg::*;

   localparam int NUM_DIRECTED   = 20;
   localparam int NUM_RANDOM     = 1330;
   localparam int QUIET_TAIL     = 150;   // last beats go back to back
   localparam int DRAIN_CYCLES   = 8;     // covers the input, day number and result registers
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int COUNT_SAT      = (1 << COUNT_W) - 1;

   // One directed vector: both dates, and an expected result that is used
   // only when use_fixed is set; other rows go through the model.
   typedef struct packed {
      logic [DAY_W-1:0]   da;
      logic [MONTH_W-1:0] ma;
      logic [YEAR_W-1:0]  ya;
      logic [DAY_W-1:0]   db;
      logic [MONTH_W-1:0] mb;
      logic [YEAR_W-1:0]  yb;
      logic               use_fixed;
      logic [COUNT_W-1:0] cnt;
      logic               early;
      logic               bad;
   } vector_type;

   localparam vector_type DIRECTED_VECTORS [NUM_DIRECTED] = '{
      // equal dates at the very start of the calendar
      '{1,  1,  0,     1,  1,  0,     1, 0,       0, 0},
      // widest span, both directions
      '{1,  1,  0,     31, 12, 9999,  1, 3652499, 1, 0},
      '{31, 12, 9999,  1,  1,  0,     1, 3652499, 0, 0},
      // invalid month codes
      '{1,  0,  2000,  1,  1,  2000,  1, 0,       0, 1},
      '{1,  1,  2000,  1,  13, 2000,  1, 0,       0, 1},
      '{15, 15, 2000,  15, 6,  2000,  1, 0,       0, 1},
      // day zero, day past a 30 day month, leap day in a common year
      '{0,  5,  1999,  1,  5,  1999,  1, 0,       0, 1},
      '{10, 3,  1999,  31, 4,  1999,  1, 0,       0, 1},
      '{29, 2,  2001,  1,  3,  2001,  1, 0,       0, 1},
      // year beyond the limit, and every input bit set
      '{1,  1,  10000, 1,  1,  1,     1, 0,       0, 1},
      '{1,  1,  1,     1,  1,  16383, 1, 0,       0, 1},
      '{31, 15, 16383, 31, 15, 16383, 1, 0,       0, 1},
      // leap days that are valid, year zero counts as leap
      '{29, 2,  2000,  1,  3,  2000,  0, 0,       0, 0},
      '{29, 2,  0,     1,  3,  0,     0, 0,       0, 0},
      '{28, 2,  1900,  1,  3,  1900,  0, 0,       0, 0},
      '{29, 2,  2024,  29, 2,  2024,  1, 0,       0, 0},
      // across a year end, second date earlier, same year spread
      '{31, 12, 2003,  1,  1,  2004,  0, 0,       0, 0},
      '{2,  1,  5000,  1,  1,  5000,  0, 0,       0, 0},
      '{1,  1,  7777,  31, 12, 7777,  0, 0,       0, 0},
      '{31, 12, 9999,  30, 12, 9999,  0, 0,       0, 0}
   };

   // Calendar tables of a common year, indexed by month code.
   localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
      0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0
   };
   localparam logic [8:0] DAYS_AHEAD [16] = '{
      0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 0, 0, 0
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   // Side band for the monitor: directed rows may carry their own answer.
   logic            use_fixed = 1'b0;
   rsp_payload_type fixed_rsp = '0;

   rsp_payload_type pending_counts[$];
   int              err_count = 0;
   int              idle_cycles = 0;
   bit              bursty = 1'b1;

   date_day_difference_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Calendar model
   // ------------------------------------------------------------------------

   // Length of a month; February grows to 29 in every fourth year.
   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic [YEAR_W-1:0]  y);
      if (m == MONTH_FEB && y[1:0] == 2'b00) begin
         return FEB_LEAP_LEN;
      end
      return MONTH_DAYS[m];
   endfunction

   function automatic logic date_valid(input logic [DAY_W-1:0]   d,
                                       input logic [MONTH_W-1:0] m,
                                       input logic [YEAR_W-1:0]  y);
      return m >= MONTH_JAN && m <= MONTH_DEC && y <= YEAR_MAX &&
             d != '0 && d <= days_in_month(m, y);
   endfunction

   // Absolute day number: whole years, leap days of earlier years, earlier
   // months, then the day itself.
   function automatic logic [31:0] day_index(input logic [DAY_W-1:0]   d,
                                             input logic [MONTH_W-1:0] m,
                                             input logic [YEAR_W-1:0]  y);
      logic [31:0] n;
      n = 32'(y) * 32'd365 + (32'(y) + 32'd3) / 32'd4 + 32'(DAYS_AHEAD[m]) + 32'(d);
      if (m > MONTH_FEB && y[1:0] == 2'b00) begin
         n = n + 32'd1;
      end
      return n;
   endfunction

   function automatic rsp_payload_type count_days_between(input req_payload_type p);
      rsp_payload_type r;
      logic [31:0]     na;
      logic [31:0]     nb;
      logic [31:0]     span;
      r = '0;
      if (!date_valid(p.day_a, p.month_a, p.year_a) ||
          !date_valid(p.day_b, p.month_b, p.year_b)) begin
         r.bad_date = 1'b1;
         return r;
      end
      na   = day_index(p.day_a, p.month_a, p.year_a);
      nb   = day_index(p.day_b, p.month_b, p.year_b);
      span = (na < nb) ? nb - na : na - nb;
      // clip at the top of the count field
      if (span > 32'(COUNT_SAT)) begin
         span = 32'(COUNT_SAT);
      end
      r.day_count     = span[COUNT_W-1:0];
      r.first_earlier = na < nb;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Draw a valid date, leaning on the calendar edges.
   function automatic date_type pick_date();
      date_type         dt;
      logic [DAY_W-1:0] len;
      case ($urandom_range(0, 9))
         0:       dt.year = YEAR_W'($urandom_range(0, 7));
         1:       dt.year = YEAR_W'($urandom_range(9992, 9999));
         2:       dt.year = YEAR_W'(4 * $urandom_range(0, 2499));
         default: dt.year = YEAR_W'($urandom_range(0, 9999));
      endcase
      dt.month = MONTH_W'($urandom_range(1, 12));
      len      = days_in_month(dt.month, dt.year);
      case ($urandom_range(0, 5))
         0:       dt.day = DAY_W'(1);
         1:       dt.day = len;
         default: dt.day = DAY_W'($urandom_range(1, len));
      endcase
      return dt;
   endfunction

   function automatic req_payload_type pick_pair();
      req_payload_type  p;
      date_type         a;
      date_type         b;
      logic [DAY_W-1:0] len;
      int               kind;
      kind = $urandom_range(0, 99);
      // raw noise: every bit of every field free
      if (kind < 10) begin
         p.day_a   = DAY_W'($urandom);
         p.month_a = MONTH_W'($urandom);
         p.year_a  = YEAR_W'($urandom);
         p.day_b   = DAY_W'($urandom);
         p.month_b = MONTH_W'($urandom);
         p.year_b  = YEAR_W'($urandom);
         return p;
      end
      a = pick_date();
      b = pick_date();
      if (kind < 30) begin
         b = a;
      end else if (kind < 50) begin
         // keep the second date close: same or next year, sometimes same month
         b.year = (a.year < YEAR_MAX && $urandom_range(0, 3) == 0) ? a.year + 1'b1 : a.year;
         if ($urandom_range(0, 1) == 1) begin
            b.month = a.month;
         end
         len = days_in_month(b.month, b.year);
         if (b.day > len) begin
            b.day = len;
         end
      end
      p = {a.day, a.month, a.year, b.day, b.month, b.year};
      if (kind >= 90) begin
         // break exactly one field of an otherwise sane pair
         case ($urandom_range(0, 5))
            0: p.day_a = '0;
            1: begin
               len     = days_in_month(p.month_b, p.year_b);
               p.day_b = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
            end
            2: p.month_a = $urandom_range(0, 1) ? MONTH_W'(0) :
                                                  MONTH_W'($urandom_range(13, 15));
            3: p.month_b = $urandom_range(0, 1) ? MONTH_W'(0) :
                                                  MONTH_W'($urandom_range(13, 15));
            4: p.year_a = YEAR_W'($urandom_range(YEAR_MAX + 1, 16383));
            default: p.year_b = YEAR_W'($urandom_range(YEAR_MAX + 1, 16383));
         endcase
      end
      return p;
   endfunction

   // Present one beat at the falling edge and hold it until it is taken.
   task automatic drive_beat(input req_payload_type p, input logic fixed,
                             input rsp_payload_type answer);
      @(negedge clock);
      start     <= 1'b1;
      req_data  <= p;
      use_fixed <= fixed;
      fixed_rsp <= answer;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a random burst, in bursty stretches only.
   task automatic sender_pause(input bit allowed);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         bursty = !bursty;
      end
      if (allowed && bursty && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: score each result strobe against the oldest expectation, then
   // record the expectation for a beat taken at this edge.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input int want, input int got);
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      err_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_counts.size() == 0) begin
               $display("%0t ns: unexpected result, expected none actual %p",
                        $time, rsp_data);
               err_count++;
            end else begin
               want = pending_counts.pop_front();
               if (rsp_data.day_count !== want.day_count)
                  report_mismatch("day_count", want.day_count, rsp_data.day_count);
               if (rsp_data.first_earlier !== want.first_earlier)
                  report_mismatch("first_earlier", want.first_earlier,
                                  rsp_data.first_earlier);
               if (rsp_data.bad_date !== want.bad_date)
                  report_mismatch("bad_date", want.bad_date, rsp_data.bad_date);
            end
         end
         if (start && !busy) begin
            pending_counts.push_back(use_fixed ? fixed_rsp : count_days_between(req_data));
         end
      end
   end

   // Watchdog: advance a counter on every edge where nothing moves.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("date_day_difference_top test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      vector_type      v;
      rsp_payload_type answer;
      // hold reset, then release it on a falling edge
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         v      = DIRECTED_VECTORS[i];
         answer = {v.cnt, v.early, v.bad};
         drive_beat({v.da, v.ma, v.ya, v.db, v.mb, v.yb}, v.use_fixed, answer);
         sender_pause(1'b1);
      end

      // random pairs; the tail runs back to back
      for (int i = 0; i < NUM_RANDOM; i++) begin
         drive_beat(pick_pair(), 1'b0, '0);
         sender_pause(i < NUM_RANDOM - QUIET_TAIL);
      end
      @(negedge clock);
      start <= 1'b0;

      // wait for the last beats to come out, then let the pipe run empty
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("date_day_difference_top test passed");
      end else begin
         $display("date_day_difference_top test failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/dd_pkg.sv
rtl/dd_day_num.sv
rtl/dd_diff.sv
rtl/date_day_difference_top.sv
dv/tb_date_day_difference_top.sv
